>>> design/go_back_n_send_queues_macros.svh
// Assertion macros used by the checker file gbn_chk.sv.
`ifndef GO_BACK_N_SEND_QUEUES_MACROS_SVH
`define GO_BACK_N_SEND_QUEUES_MACROS_SVH

// Same-cycle implication, checked at each rising clk edge outside reset.
`define GBN_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("go-back-n queue check failed");

// Next-cycle implication.
`define GBN_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("go-back-n queue check failed");

`endif

>>> design/gbn_pkg.sv
package gbn_pkg;

	localparam int QUEUE_COUNT_DEF = 7;
	localparam int QUEUE_DEPTH_DEF = 64;

	localparam logic [1:0] ACT_ENQ  = 2'd0;
	localparam logic [1:0] ACT_SEND = 2'd1;
	localparam logic [1:0] ACT_ACK  = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	localparam logic [16:0] HDR_BYTES = 17'd4;
	localparam logic [3:0] WINDOW_RST = 4'd8;

	typedef struct packed {
		logic [15:0] handle;
		logic [15:0] len;
		logic [7:0]  ptype;
		logic [3:0]  seq;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] handle;
		logic [16:0] length;
		logic [7:0]  ptype;
		logic [3:0]  seq;
		logic        rewound;
		logic [6:0]  stored;
		logic [6:0]  unconf;
	} result_t;

endpackage

>>> design/gbn_ram.sv
module gbn_ram
	import gbn_pkg::*;
#(
	parameter int WIDTH = ENTRY_W,
	parameter int DEPTH = QUEUE_COUNT_DEF * QUEUE_DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/gbn_step.sv
module gbn_step
	import gbn_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	localparam int SW = $clog2(QUEUE_DEPTH),
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic [1:0]    action,
	input  logic [3:0]    ack_seq,
	input  logic [3:0]    window,
	input  logic          q_ok,
	input  logic [SW-1:0] head,
	input  logic [CW-1:0] cnt,
	input  logic [CW-1:0] unack,
	input  logic [4:0]    nseq,
	input  entry_t        ent,
	input  entry_t        new_ent,
	output logic [SW-1:0] head_n,
	output logic [CW-1:0] cnt_n,
	output logic [CW-1:0] unack_n,
	output logic [4:0]    nseq_n,
	output logic          wr_en,
	output entry_t        wr_ent,
	output result_t       res
);

	logic [3:0]    ack_gap;
	logic [CW-1:0] rel;
	logic [SW:0]   hsum;
	logic [4:0]    nseq_eff;
	logic [3:0]    os;

	always_comb begin
		head_n   = head;
		cnt_n    = cnt;
		unack_n  = unack;
		nseq_n   = nseq;
		wr_en    = 1'b0;
		wr_ent   = new_ent;
		res      = '0;
		ack_gap  = ack_seq - ent.seq;
		rel      = (CW'(ack_gap) > cnt) ? cnt : CW'(ack_gap);
		hsum     = (SW+1)'(head) + (SW+1)'(rel);
		nseq_eff = nseq;
		os       = nseq[3:0];
		if (!q_ok) begin
			res.status = STAT_EMPTY;
		end else begin
			case (action)
				ACT_ENQ: begin
					if (cnt == CW'(QUEUE_DEPTH)) begin
						res.status = STAT_FULL;
					end else begin
						wr_en = 1'b1;
						cnt_n = cnt + CW'(1);
					end
				end
				ACT_SEND: begin
					if (unack >= cnt) begin
						res.status = STAT_EMPTY;
					end else begin
						unack_n = unack + CW'(1);
						// window full: restart from the head, renumber from its seq
						if (unack >= CW'(window)) begin
							unack_n     = CW'(1);
							nseq_eff    = {1'b0, ent.seq};
							res.rewound = 1'b1;
						end
						// restart mark: resend keeps the stored number
						if (nseq_eff[4]) begin
							os = ent.seq;
						end else begin
							os         = nseq_eff[3:0];
							wr_en      = 1'b1;
							wr_ent     = ent;
							wr_ent.seq = os;
						end
						nseq_n     = {1'b0, os + 4'd1};
						res.handle = ent.handle;
						res.length = 17'(ent.len) + HDR_BYTES;
						res.ptype  = ent.ptype;
						res.seq    = os;
					end
				end
				ACT_ACK: begin
					if (cnt == '0) begin
						res.status = STAT_EMPTY;
					end else if (ent.seq != ack_seq) begin
						head_n  = (hsum >= (SW+1)'(QUEUE_DEPTH)) ?
							SW'(hsum - (SW+1)'(QUEUE_DEPTH)) : SW'(hsum);
						cnt_n   = cnt - rel;
						unack_n = (unack > rel) ? unack - rel : '0;
					end else begin
						unack_n = '0;
						nseq_n  = {1'b1, nseq[3:0]};
					end
				end
				default: begin
				end
			endcase
		end
		res.stored = q_ok ? 7'(cnt_n) : '0;
		res.unconf = q_ok ? 7'(unack_n) : '0;
	end

endmodule

>>> design/go_back_n_send_queues.sv
// Accepted input passes the input register, update stage and result register.
// Throughput: one transaction per cycle unless out_stall holds it, also back to back
// on one queue; the entry RAM read and update-stage state forwarding set the pace.
// Reset (arst_n low, asynchronous): all queues empty, sequence state cleared,
// window_size = 8. The entry RAM is not cleared; only written entries are read.
module go_back_n_send_queues
	import gbn_pkg::*;
#(
	parameter int QUEUE_COUNT = QUEUE_COUNT_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	localparam int SW  = $clog2(QUEUE_DEPTH),
	localparam int CW  = $clog2(QUEUE_DEPTH + 1),
	localparam int QIW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1,
	localparam int RD  = QUEUE_COUNT * QUEUE_DEPTH,
	localparam int AW  = (RD > 1) ? $clog2(RD) : 1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [2:0]  queue_id,
	input  logic [15:0] buffer_handle,
	input  logic [15:0] length,
	input  logic [7:0]  packet_type,
	input  logic [3:0]  ack_seq,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] out_handle,
	output logic [16:0] out_length,
	output logic [7:0]  out_type,
	output logic [3:0]  out_seq,
	output logic        rewound,
	output logic [6:0]  stored_count,
	output logic [6:0]  unconfirmed_count
);

	logic [3:0]    window_q;
	logic [SW-1:0] head_q  [QUEUE_COUNT];
	logic [CW-1:0] cnt_q   [QUEUE_COUNT];
	logic [CW-1:0] unack_q [QUEUE_COUNT];
	logic [4:0]    nseq_q  [QUEUE_COUNT];

	// stage 1: input register, RAM read issue
	logic          s1_v_q;
	logic [1:0]    action_s1;
	logic [2:0]    qid_s1;
	logic [15:0]   handle_s1;
	logic [15:0]   length_s1;
	logic [7:0]    ptype_s1;
	logic [3:0]    ack_s1;

	// stage 2: RAM data, state update
	logic          s2_v_q;
	logic [1:0]    action_s2;
	logic          q_ok_s2;
	logic [QIW-1:0] qidx_s2;
	logic [15:0]   handle_s2;
	logic [15:0]   length_s2;
	logic [7:0]    ptype_s2;
	logic [3:0]    ack_s2;
	logic [SW-1:0] head_s2;
	logic [CW-1:0] cnt_s2;
	logic [CW-1:0] unack_s2;
	logic [4:0]    nseq_s2;
	logic [SW-1:0] slot_s2;
	logic          byp_s2;
	entry_t        byp_ent_s2;

	logic          out_valid_q;
	result_t       res_q;

	logic          s1_adv;
	logic          s2_done;
	logic          in_acc;

	logic          q_ok_s1;
	logic [QIW-1:0] qidx_s1;
	logic [QIW-1:0] qsel_s1;
	logic          same_q;
	logic [SW-1:0] head_v;
	logic [CW-1:0] cnt_v;
	logic [CW-1:0] unack_v;
	logic [4:0]    nseq_v;
	logic [SW:0]   enq_sum;
	logic [SW:0]   snd_sum;
	logic [SW-1:0] enq_slot;
	logic [SW-1:0] snd_slot;
	logic [SW-1:0] slot_v;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;

	entry_t        ram_rdata;
	entry_t        ent_s2;
	entry_t        new_ent_s2;
	entry_t        wr_ent;
	logic          wr_en;
	logic          ram_we;
	logic [SW-1:0] head_n;
	logic [CW-1:0] cnt_n;
	logic [CW-1:0] unack_n;
	logic [4:0]    nseq_n;
	result_t       res_n;

	assign cfg_ready = 1'b1;

	assign s2_done  = s2_v_q && (!out_valid_q || !out_stall);
	assign s1_adv   = s1_v_q && (!s2_v_q || s2_done);
	assign in_stall = s1_v_q && !s1_adv;
	assign in_acc   = in_valid && !in_stall;

	assign q_ok_s1 = 32'(qid_s1) < QUEUE_COUNT;
	assign qidx_s1 = QIW'(qid_s1);
	assign qsel_s1 = q_ok_s1 ? qidx_s1 : '0;

	// forward the state the item in stage 2 commits this cycle
	assign same_q  = s2_done && q_ok_s2 && (qidx_s2 == qidx_s1);
	assign head_v  = same_q ? head_n  : head_q[qsel_s1];
	assign cnt_v   = same_q ? cnt_n   : cnt_q[qsel_s1];
	assign unack_v = same_q ? unack_n : unack_q[qsel_s1];
	assign nseq_v  = same_q ? nseq_n  : nseq_q[qsel_s1];

	assign enq_sum  = (SW+1)'(head_v) + (SW+1)'(cnt_v);
	assign snd_sum  = (SW+1)'(head_v) + (SW+1)'(unack_v);
	assign enq_slot = (enq_sum >= (SW+1)'(QUEUE_DEPTH)) ?
		SW'(enq_sum - (SW+1)'(QUEUE_DEPTH)) : SW'(enq_sum);
	assign snd_slot = (snd_sum >= (SW+1)'(QUEUE_DEPTH)) ?
		SW'(snd_sum - (SW+1)'(QUEUE_DEPTH)) : SW'(snd_sum);

	always_comb begin
		case (action_s1)
			ACT_ENQ:  slot_v = enq_slot;
			ACT_SEND: slot_v = (unack_v >= CW'(window_q)) ? head_v : snd_slot;
			default:  slot_v = head_v;
		endcase
	end

	assign rd_addr = AW'(qsel_s1) * AW'(QUEUE_DEPTH) + AW'(slot_v);
	assign wr_addr = AW'(qidx_s2) * AW'(QUEUE_DEPTH) + AW'(slot_s2);
	assign ram_we  = s2_done && q_ok_s2 && wr_en;

	gbn_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(RD)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_addr),
		.wdata(wr_ent),
		.re   (s1_adv),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	assign ent_s2     = byp_s2 ? byp_ent_s2 : ram_rdata;
	assign new_ent_s2 = '{handle: handle_s2, len: length_s2, ptype: ptype_s2, seq: 4'd0};

	gbn_step #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_step (
		.action (action_s2),
		.ack_seq(ack_s2),
		.window (window_q),
		.q_ok   (q_ok_s2),
		.head   (head_s2),
		.cnt    (cnt_s2),
		.unack  (unack_s2),
		.nseq   (nseq_s2),
		.ent    (ent_s2),
		.new_ent(new_ent_s2),
		.head_n (head_n),
		.cnt_n  (cnt_n),
		.unack_n(unack_n),
		.nseq_n (nseq_n),
		.wr_en  (wr_en),
		.wr_ent (wr_ent),
		.res    (res_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= WINDOW_RST;
			s1_v_q      <= 1'b0;
			s2_v_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < QUEUE_COUNT; i++) begin
				head_q[i]  <= '0;
				cnt_q[i]   <= '0;
				unack_q[i] <= '0;
				nseq_q[i]  <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				window_q <= cfg_data;
			end
			if (in_acc) begin
				s1_v_q <= 1'b1;
			end else if (s1_adv) begin
				s1_v_q <= 1'b0;
			end
			if (s1_adv) begin
				s2_v_q <= 1'b1;
			end else if (s2_done) begin
				s2_v_q <= 1'b0;
			end
			if (s2_done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (s2_done && q_ok_s2) begin
				head_q[qidx_s2]  <= head_n;
				cnt_q[qidx_s2]   <= cnt_n;
				unack_q[qidx_s2] <= unack_n;
				nseq_q[qidx_s2]  <= nseq_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			action_s1 <= action;
			qid_s1    <= queue_id;
			handle_s1 <= buffer_handle;
			length_s1 <= length;
			ptype_s1  <= packet_type;
			ack_s1    <= ack_seq;
		end
		if (s1_adv) begin
			action_s2  <= action_s1;
			q_ok_s2    <= q_ok_s1;
			qidx_s2    <= qsel_s1;
			handle_s2  <= handle_s1;
			length_s2  <= length_s1;
			ptype_s2   <= ptype_s1;
			ack_s2     <= ack_s1;
			head_s2    <= head_v;
			cnt_s2     <= cnt_v;
			unack_s2   <= unack_v;
			nseq_s2    <= nseq_v;
			slot_s2    <= slot_v;
			// RAM returns the old word when stage 2 writes the same entry now
			byp_s2     <= ram_we && (wr_addr == rd_addr);
			byp_ent_s2 <= wr_ent;
		end
		if (s2_done) begin
			res_q <= res_n;
		end
	end

	assign out_valid         = out_valid_q;
	assign status            = res_q.status;
	assign out_handle        = res_q.handle;
	assign out_length        = res_q.length;
	assign out_type          = res_q.ptype;
	assign out_seq           = res_q.seq;
	assign rewound           = res_q.rewound;
	assign stored_count      = res_q.stored;
	assign unconfirmed_count = res_q.unconf;

endmodule

>>> design/gbn_chk.sv
`include "go_back_n_send_queues_macros.svh"

module gbn_chk
	import gbn_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [15:0] out_handle,
	input logic [16:0] out_length,
	input logic [7:0]  out_type,
	input logic [3:0]  out_seq,
	input logic        rewound,
	input logic [6:0]  stored_count,
	input logic [6:0]  unconfirmed_count
);

	// a stalled result transaction stays put
	`GBN_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(out_handle) && $stable(out_seq))

	// failed steps carry no descriptor
	`GBN_ASSERT_IMPL(a_fail_zero, out_valid && status != STAT_OK, out_handle == '0 && out_length == '0 && out_type == '0 && out_seq == '0 && !rewound)

	// never more sent than held
	`GBN_ASSERT_IMPL(a_unconf_le, out_valid, unconfirmed_count <= stored_count)

	// a window rewind restarts at the head: exactly one outstanding after it
	`GBN_ASSERT_IMPL(a_rewind, out_valid && rewound, status == STAT_OK && unconfirmed_count == 7'd1 && out_length >= 17'd4)

endmodule

bind go_back_n_send_queues gbn_chk u_gbn_chk (.*);
